### rtl/core/smx_pkg.sv
`default_nettype none
package smx_pkg;

  localparam int OPC_W  = 4;
  localparam int LVL_W  = 4;
  localparam int WORD_W = 32;
  localparam int PC_O_W = 7;
  localparam int BP_O_W = 6;
  localparam int SP_O_W = 7;
  localparam int FLT_W  = 2;

  typedef logic [OPC_W-1:0]  opcode_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [FLT_W-1:0]  fault_t;

  // Instruction opcodes.
  localparam opcode_t OP_LIT = 4'd1;
  localparam opcode_t OP_OPR = 4'd2;
  localparam opcode_t OP_LOD = 4'd3;
  localparam opcode_t OP_STO = 4'd4;
  localparam opcode_t OP_CAL = 4'd5;
  localparam opcode_t OP_INC = 4'd6;
  localparam opcode_t OP_JMP = 4'd7;
  localparam opcode_t OP_JPC = 4'd8;
  localparam opcode_t OP_SYS = 4'd9;

  // OPR selectors.
  localparam word_t OPR_RTN = 32'd0;
  localparam word_t OPR_NEG = 32'd1;
  localparam word_t OPR_ADD = 32'd2;
  localparam word_t OPR_SUB = 32'd3;
  localparam word_t OPR_MUL = 32'd4;
  localparam word_t OPR_DIV = 32'd5;
  localparam word_t OPR_ODD = 32'd6;
  localparam word_t OPR_MOD = 32'd7;
  localparam word_t OPR_EQL = 32'd8;
  localparam word_t OPR_NEQ = 32'd9;
  localparam word_t OPR_LSS = 32'd10;
  localparam word_t OPR_LEQ = 32'd11;
  localparam word_t OPR_GTR = 32'd12;
  localparam word_t OPR_GEQ = 32'd13;

  // SYS functions.
  localparam word_t SYS_WRITE = 32'd1;
  localparam word_t SYS_READ  = 32'd2;
  localparam word_t SYS_HALT  = 32'd3;

  // Fault codes.
  localparam fault_t FLT_NONE  = 2'd0;
  localparam fault_t FLT_STACK = 2'd1;
  localparam fault_t FLT_DIV0  = 2'd2;
  localparam fault_t FLT_JUMP  = 2'd3;

endpackage
`default_nettype wire

### rtl/core/smx_if.sv
`default_nettype none
interface smx_in_if;
  logic                              valid;
  logic                              ready;
  logic [smx_pkg::OPC_W-1:0]         opcode;
  logic [smx_pkg::LVL_W-1:0]         level;
  logic signed [smx_pkg::WORD_W-1:0] modifier;
  logic signed [smx_pkg::WORD_W-1:0] read_value;

  modport source (output valid, opcode, level, modifier, read_value, input ready);
  modport sink   (input valid, opcode, level, modifier, read_value, output ready);
endinterface

interface smx_out_if;
  logic                              valid;
  logic                              ready;
  logic [smx_pkg::PC_O_W-1:0]        next_pc;
  logic [smx_pkg::BP_O_W-1:0]        frame_base_out;
  logic signed [smx_pkg::SP_O_W-1:0] stack_top_index;
  logic signed [smx_pkg::WORD_W-1:0] top_value;
  logic                              write_valid;
  logic signed [smx_pkg::WORD_W-1:0] write_value;
  logic                              halted_out;
  logic [smx_pkg::FLT_W-1:0]         fault;

  modport source (output valid, next_pc, frame_base_out, stack_top_index, top_value,
                  write_valid, write_value, halted_out, fault, input ready);
  modport sink   (input valid, next_pc, frame_base_out, stack_top_index, top_value,
                  write_valid, write_value, halted_out, fault, output ready);
endinterface
`default_nettype wire

### rtl/core/smx_ram.sv
`default_nettype none
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/smx_div.sv
`default_nettype none
module smx_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [smx_pkg::WORD_W-1:0] dividend,
  input  wire logic [smx_pkg::WORD_W-1:0] divisor,
  output logic                         done,
  output logic [smx_pkg::WORD_W-1:0]   quot,
  output logic [smx_pkg::WORD_W-1:0]   rem
);

  localparam int W = smx_pkg::WORD_W;

  logic         busy_r, done_r;
  logic [4:0]   cnt_r;
  logic [W-1:0] q_r, r_r, d_r;
  logic         negq_r, negr_r;
  logic [W:0]   sh, diff;

  // One quotient bit per cycle on magnitudes; signs fixed at the end.
  assign sh   = {r_r, q_r[W-1]};
  assign diff = sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
      d_r    <= divisor[W-1] ? (~divisor + 1'b1) : divisor;
      r_r    <= '0;
      negq_r <= dividend[W-1] ^ divisor[W-1];
      negr_r <= dividend[W-1];
    end else if (busy_r) begin
      if (!diff[W]) begin
        r_r <= diff[W-1:0];
        q_r <= {q_r[W-2:0], 1'b1};
      end else begin
        r_r <= sh[W-1:0];
        q_r <= {q_r[W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = negq_r ? (~q_r + 1'b1) : q_r;
  assign rem  = negr_r ? (~r_r + 1'b1) : r_r;

endmodule
`default_nettype wire

### rtl/core/stack_machine_execute.sv
`default_nettype none
// Executes one P-machine instruction per request and returns one result per
// request. The data stack lives in a single synchronous RAM with one write and
// one registered read port; after reset a clearing pass writes zero to every
// entry, during which no request is taken. Unless halted, every instruction
// then goes through a sequencer that reads the top two stack entries, walks
// 'level' static links for LOD, STO and CAL (S_WALK then S_WHOP per hop),
// reads two frame words, executes, and reads back the new top. A request is
// accepted only in the idle state and its result is loaded into the output
// register in S_OUT; no request is taken while one is in progress. A division
// or modulo by a non-zero divisor waits in S_DIVW (one quotient bit per cycle
// in the divider) and a call passes through S_WR for its extra frame writes.
// Once halted, a request goes from idle straight to reading back the top. The
// result sits in an output register, so the next request is taken while a
// result waits; the sequencer only stalls when that register is still full as
// the following result is ready.
module stack_machine_execute #(
  parameter int STACK_DEPTH = 64,
  parameter int CODE_SIZE   = 128
) (
  input  wire logic clk,
  input  wire logic rst_n,
  smx_in_if.sink    in_ch,
  smx_out_if.source out_ch
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = AW + 1;
  localparam int PCW = $clog2(CODE_SIZE);
  localparam int W   = smx_pkg::WORD_W;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RT   = 4'd2;
  localparam logic [3:0] S_RX   = 4'd3;
  localparam logic [3:0] S_XC   = 4'd4;
  localparam logic [3:0] S_WALK = 4'd5;
  localparam logic [3:0] S_WHOP = 4'd6;
  localparam logic [3:0] S_PRE  = 4'd7;
  localparam logic [3:0] S_P1   = 4'd8;
  localparam logic [3:0] S_P2   = 4'd9;
  localparam logic [3:0] S_DIVW = 4'd10;
  localparam logic [3:0] S_EXEC = 4'd11;
  localparam logic [3:0] S_WR   = 4'd12;
  localparam logic [3:0] S_TOP  = 4'd13;
  localparam logic [3:0] S_TOPW = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  function automatic logic in_stk(input logic signed [33:0] v);
    in_stk = (v >= 0) && (v < STACK_DEPTH);
  endfunction

  function automatic logic in_code(input logic signed [33:0] v);
    in_code = (v >= 0) && (v < CODE_SIZE);
  endfunction

  // Architectural state.
  logic [3:0]            state_r;
  logic [AW:0]           clr_r;
  logic signed [SPW-1:0] sp_r;
  logic [AW-1:0]         bp_r;
  logic [PCW-1:0]        pc_r;
  logic                  halt_r;

  // Per-instruction working registers.
  logic [smx_pkg::OPC_W-1:0] op_r;
  logic [smx_pkg::LVL_W-1:0] cnt_r;
  logic [W-1:0]              m_r, rd_r, t_r, x_r, d1_r, d2_r, b_r, top_r;
  logic [PCW-1:0]            npc_r;
  logic                      walk_bad_r;
  logic [AW-1:0]             cal_bp_r;
  logic [1:0]                wcnt_r;

  // Result register.
  logic                  out_valid_r;
  logic                  wv_r;
  logic [W-1:0]          wval_r;
  smx_pkg::fault_t       fault_r;

  logic signed [33:0] sp34, bp34, m34, b34, t34, x34;
  assign sp34 = {{(34-SPW){sp_r[SPW-1]}}, sp_r};
  assign bp34 = {{(34-AW){1'b0}}, bp_r};
  assign m34  = {{2{m_r[W-1]}}, m_r};
  assign b34  = {{2{b_r[W-1]}}, b_r};
  assign t34  = {{2{t_r[W-1]}}, t_r};
  assign x34  = {{2{x_r[W-1]}}, x_r};

  logic signed [33:0] bm34, a1_34;
  assign bm34  = b34 + m34;
  assign a1_34 = (op_r == smx_pkg::OP_OPR) ? (bp34 + 34'sd1) : bm34;

  // Divider for DIV and MOD.
  logic         div_start, div_done;
  logic [W-1:0] div_q, div_r;
  logic         is_divop;

  assign is_divop = (op_r == smx_pkg::OP_OPR) &&
                    ((m_r == smx_pkg::OPR_DIV) || (m_r == smx_pkg::OPR_MOD));
  assign div_start = (state_r == S_P2) && is_divop && (t_r != '0);

  smx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (x_r),
    .divisor  (t_r),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // Execute stage decisions.
  logic signed [SPW-1:0] ex_sp;
  logic [AW-1:0]         ex_bp;
  logic [PCW-1:0]        ex_pc;
  logic                  ex_halt, ex_we, ex_cal, ex_wv;
  logic [AW-1:0]         ex_waddr;
  logic [W-1:0]          ex_wdata, alu_r, mul_lo;
  smx_pkg::fault_t       ex_fault;
  logic signed [33:0]    nbp34, ra34, inc34;
  logic                  walk_fail;

  assign mul_lo = 32'(x_r * t_r);
  assign nbp34  = {{2{d1_r[W-1]}}, d1_r};
  assign ra34   = {{2{d2_r[W-1]}}, d2_r};
  assign inc34  = sp34 + m34;
  assign walk_fail = walk_bad_r || !in_stk(b34);

  always_comb begin
    case (m_r)
      smx_pkg::OPR_ADD: alu_r = x_r + t_r;
      smx_pkg::OPR_SUB: alu_r = x_r - t_r;
      smx_pkg::OPR_MUL: alu_r = mul_lo;
      smx_pkg::OPR_DIV: alu_r = (t_r == '0) ? '0 : div_q;
      smx_pkg::OPR_MOD: alu_r = (t_r == '0) ? '0 : div_r;
      smx_pkg::OPR_EQL: alu_r = {31'd0, x34 == t34};
      smx_pkg::OPR_NEQ: alu_r = {31'd0, x34 != t34};
      smx_pkg::OPR_LSS: alu_r = {31'd0, x34 <  t34};
      smx_pkg::OPR_LEQ: alu_r = {31'd0, x34 <= t34};
      smx_pkg::OPR_GTR: alu_r = {31'd0, x34 >  t34};
      default:          alu_r = {31'd0, x34 >= t34};
    endcase
  end

  always_comb begin
    ex_sp    = sp_r;
    ex_bp    = bp_r;
    ex_pc    = npc_r;
    ex_halt  = 1'b0;
    ex_we    = 1'b0;
    ex_cal   = 1'b0;
    ex_wv    = 1'b0;
    ex_waddr = sp_r[AW-1:0];
    ex_wdata = t_r;
    ex_fault = smx_pkg::FLT_NONE;
    unique case (op_r)
      smx_pkg::OP_LIT: begin
        if (!in_stk(sp34 + 34'sd1)) begin
          ex_fault = smx_pkg::FLT_STACK;
        end else begin
          ex_we    = 1'b1;
          ex_waddr = AW'(sp34 + 34'sd1);
          ex_wdata = m_r;
          ex_sp    = SPW'(sp34 + 34'sd1);
        end
      end
      smx_pkg::OP_OPR: begin
        if (m_r == smx_pkg::OPR_RTN) begin
          if (!in_stk(sp34) || !in_stk(bp34 - 34'sd1) || !in_stk(bp34 + 34'sd2) ||
              !in_stk(nbp34)) begin
            ex_fault = smx_pkg::FLT_STACK;
          end else if (!in_code(ra34)) begin
            ex_fault = smx_pkg::FLT_JUMP;
          end else begin
            ex_we    = 1'b1;
            ex_waddr = AW'(bp34 - 34'sd1);
            ex_wdata = t_r;
            ex_sp    = SPW'(bp34 - 34'sd1);
            ex_bp    = AW'(nbp34);
            ex_pc    = PCW'(ra34);
          end
        end else if ((m_r == smx_pkg::OPR_NEG) || (m_r == smx_pkg::OPR_ODD)) begin
          if (!in_stk(sp34)) begin
            ex_fault = smx_pkg::FLT_STACK;
          end else begin
            ex_we    = 1'b1;
            ex_wdata = (m_r == smx_pkg::OPR_NEG) ? (~t_r + 1'b1) : {31'd0, t_r[0]};
          end
        end else if ((m_r >= smx_pkg::OPR_ADD) && (m_r <= smx_pkg::OPR_GEQ)) begin
          if (!in_stk(sp34) || (sp34 < 34'sd1)) begin
            ex_fault = smx_pkg::FLT_STACK;
          end else begin
            if (is_divop && (t_r == '0)) begin
              ex_fault = smx_pkg::FLT_DIV0;
            end
            ex_we    = 1'b1;
            ex_waddr = AW'(sp34 - 34'sd1);
            ex_wdata = alu_r;
            ex_sp    = SPW'(sp34 - 34'sd1);
          end
        end
      end
      smx_pkg::OP_LOD: begin
        if (walk_fail || !in_stk(bm34) || !in_stk(sp34 + 34'sd1)) begin
          ex_fault = smx_pkg::FLT_STACK;
        end else begin
          ex_we    = 1'b1;
          ex_waddr = AW'(sp34 + 34'sd1);
          ex_wdata = d1_r;
          ex_sp    = SPW'(sp34 + 34'sd1);
        end
      end
      smx_pkg::OP_STO: begin
        if (walk_fail || !in_stk(bm34) || !in_stk(sp34)) begin
          ex_fault = smx_pkg::FLT_STACK;
        end else begin
          ex_we    = 1'b1;
          ex_waddr = AW'(bm34);
          ex_wdata = t_r;
          ex_sp    = SPW'(sp34 - 34'sd1);
        end
      end
      smx_pkg::OP_CAL: begin
        if (walk_fail || !in_stk(sp34) || !in_stk(sp34 + 34'sd4)) begin
          ex_fault = smx_pkg::FLT_STACK;
        end else if (!in_code(m34)) begin
          ex_fault = smx_pkg::FLT_JUMP;
        end else begin
          ex_we    = 1'b1;
          ex_cal   = 1'b1;
          ex_waddr = AW'(sp34 + 34'sd1);
          ex_wdata = b_r;
          ex_bp    = AW'(sp34 + 34'sd1);
          ex_pc    = PCW'(m34);
        end
      end
      smx_pkg::OP_INC: begin
        if ((inc34 < -34'sd1) || (inc34 >= STACK_DEPTH)) begin
          ex_fault = smx_pkg::FLT_STACK;
        end else begin
          ex_sp = SPW'(inc34);
        end
      end
      smx_pkg::OP_JMP: begin
        if (!in_code(m34)) begin
          ex_fault = smx_pkg::FLT_JUMP;
        end else begin
          ex_pc = PCW'(m34);
        end
      end
      smx_pkg::OP_JPC: begin
        if (!in_stk(sp34)) begin
          ex_fault = smx_pkg::FLT_STACK;
        end else if ((t_r == '0) && !in_code(m34)) begin
          ex_fault = smx_pkg::FLT_JUMP;
        end else begin
          if (t_r == '0) begin
            ex_pc = PCW'(m34);
          end
          ex_sp = SPW'(sp34 - 34'sd1);
        end
      end
      smx_pkg::OP_SYS: begin
        if (m_r == smx_pkg::SYS_WRITE) begin
          if (!in_stk(sp34)) begin
            ex_fault = smx_pkg::FLT_STACK;
          end else begin
            ex_wv = 1'b1;
            ex_sp = SPW'(sp34 - 34'sd1);
          end
        end else if (m_r == smx_pkg::SYS_READ) begin
          if (!in_stk(sp34 + 34'sd1)) begin
            ex_fault = smx_pkg::FLT_STACK;
          end else begin
            ex_we    = 1'b1;
            ex_waddr = AW'(sp34 + 34'sd1);
            ex_wdata = rd_r;
            ex_sp    = SPW'(sp34 + 34'sd1);
          end
        end else if (m_r == smx_pkg::SYS_HALT) begin
          ex_halt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Stack memory ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [W-1:0]  ram_wdata, ram_rdata;
  logic [AW:0]   cal_off;

  assign cal_off = {{(AW-1){1'b0}}, wcnt_r} + 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r[AW-1:0];
    ram_wdata = '0;
    case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
      end
      S_EXEC: begin
        ram_we    = ex_we;
        ram_waddr = ex_waddr;
        ram_wdata = ex_wdata;
      end
      S_WR: begin
        // Call frame: dynamic link, return address, copy of caller top.
        ram_we    = 1'b1;
        ram_waddr = AW'(sp34 + {{(33-AW){1'b0}}, cal_off});
        case (wcnt_r)
          2'd1:    ram_wdata = {{(W-AW){1'b0}}, cal_bp_r};
          2'd2:    ram_wdata = {{(W-PCW){1'b0}}, npc_r};
          default: ram_wdata = t_r;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (state_r)
      S_RX:    ram_raddr = AW'(sp34 - 34'sd1);
      S_WALK:  ram_raddr = b_r[AW-1:0];
      S_PRE:   ram_raddr = AW'(a1_34);
      S_P1:    ram_raddr = AW'(bp34 + 34'sd2);
      default: ram_raddr = sp_r[AW-1:0];
    endcase
  end

  smx_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic out_free;
  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      sp_r        <= '1;
      bp_r        <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result replaces the one being taken; otherwise a taken result
      // empties the output register.
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AW+1)'(STACK_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            state_r <= halt_r ? S_TOP : S_RT;
          end
        end
        S_RT:   state_r <= S_RX;
        S_RX:   state_r <= S_XC;
        S_XC:   state_r <= S_WALK;
        S_WALK: begin
          state_r <= ((cnt_r == '0) || !in_stk(b34)) ? S_PRE : S_WHOP;
        end
        S_WHOP: state_r <= S_WALK;
        S_PRE:  state_r <= S_P1;
        S_P1:   state_r <= S_P2;
        S_P2:   state_r <= div_start ? S_DIVW : S_EXEC;
        S_DIVW: begin
          if (div_done) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          sp_r    <= ex_sp;
          bp_r    <= ex_bp;
          pc_r    <= ex_pc;
          halt_r  <= ex_halt;
          state_r <= ex_cal ? S_WR : S_TOP;
        end
        S_WR: begin
          if (wcnt_r == 2'd3) begin
            state_r <= S_TOP;
          end
        end
        S_TOP:  state_r <= S_TOPW;
        S_TOPW: state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        op_r       <= in_ch.opcode;
        m_r        <= in_ch.modifier;
        rd_r       <= in_ch.read_value;
        npc_r      <= (pc_r == PCW'(CODE_SIZE - 1)) ? '0 : pc_r + 1'b1;
        b_r        <= {{(W-AW){1'b0}}, bp_r};
        walk_bad_r <= 1'b0;
        wcnt_r     <= 2'd1;
        cal_bp_r   <= bp_r;
        wv_r       <= 1'b0;
        wval_r     <= '0;
        fault_r    <= smx_pkg::FLT_NONE;
        if ((in_ch.opcode == smx_pkg::OP_LOD) || (in_ch.opcode == smx_pkg::OP_STO) ||
            (in_ch.opcode == smx_pkg::OP_CAL)) begin
          cnt_r <= in_ch.level;
        end else begin
          cnt_r <= '0;
        end
      end
      S_RX: t_r <= ram_rdata;
      S_XC: x_r <= ram_rdata;
      S_WALK: begin
        if ((cnt_r != '0) && !in_stk(b34)) begin
          walk_bad_r <= 1'b1;
        end
      end
      S_WHOP: begin
        b_r   <= ram_rdata;
        cnt_r <= cnt_r - 1'b1;
      end
      S_P1: d1_r <= ram_rdata;
      S_P2: d2_r <= ram_rdata;
      S_EXEC: begin
        fault_r <= ex_fault;
        wv_r    <= ex_wv;
        wval_r  <= ex_wv ? t_r : '0;
      end
      S_WR: wcnt_r <= wcnt_r + 1'b1;
      S_TOPW: top_r <= sp_r[SPW-1] ? '0 : ram_rdata;
      default: begin
      end
    endcase
  end

  // The result register is loaded in S_OUT; its fields only change there.
  logic [W-1:0]            o_top_r, o_wval_r;
  logic [PCW-1:0]          o_pc_r;
  logic [AW-1:0]           o_bp_r;
  logic signed [SPW-1:0]   o_sp_r;
  logic                    o_wv_r, o_halt_r;
  smx_pkg::fault_t         o_fault_r;

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      o_top_r   <= top_r;
      o_wval_r  <= wval_r;
      o_pc_r    <= pc_r;
      o_bp_r    <= bp_r;
      o_sp_r    <= sp_r;
      o_wv_r    <= wv_r;
      o_halt_r  <= halt_r;
      o_fault_r <= fault_r;
    end
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.next_pc         = smx_pkg::PC_O_W'(o_pc_r);
  assign out_ch.frame_base_out  = smx_pkg::BP_O_W'(o_bp_r);
  assign out_ch.stack_top_index = smx_pkg::SP_O_W'(o_sp_r);
  assign out_ch.top_value       = o_top_r;
  assign out_ch.write_valid     = o_wv_r;
  assign out_ch.write_value     = o_wval_r;
  assign out_ch.halted_out      = o_halt_r;
  assign out_ch.fault           = o_fault_r;

endmodule
`default_nettype wire

### tb/smx_tb_if.sv
`timescale 1ns / 1ps
// The channel interfaces come with the RTL (smx_in_if, smx_out_if). This file
// only holds the record type that the scoreboard keeps for each request.
package smx_tb_pkg;
  import smx_pkg::*;

  typedef struct packed {
    logic [6:0]  next_pc;
    logic [5:0]  frame_base_out;
    logic [6:0]  stack_top_index;
    logic [31:0] top_value;
    logic        write_valid;
    logic [31:0] write_value;
    logic        halted_out;
    logic [1:0]  fault;
  } step_result_t;
endpackage

### tb/testbench.sv
`timescale 1ns / 1ps
import smx_pkg::*;
import smx_tb_pkg::*;

// The scoreboard holds its own copy of the P-machine state. Each accepted
// request is executed on that copy and the outcome is queued; every result
// from the block is compared with the oldest queued outcome.
class pmachine_scoreboard;
  localparam int DEPTH = 64;
  localparam int CODE  = 128;

  logic [31:0]  stack_mem [DEPTH];
  longint       sp, bp, pc;
  bit           halted;
  step_result_t pending [$];
  int           errors;

  function new();
    foreach (stack_mem[i]) stack_mem[i] = '0;
    sp = -1; bp = 0; pc = 0; halted = 0; errors = 0;
  endfunction

  function bit in_stack(longint i);
    return i >= 0 && i < DEPTH;
  endfunction

  function bit in_code(longint a);
    return a >= 0 && a < CODE;
  endfunction

  // Follows the static link chain; returns 0 if any hop leaves the stack.
  function bit follow_links(int unsigned hops, output longint where);
    longint b;
    b = bp;
    where = 0;
    for (int n = 0; n < hops; n++) begin
      if (!in_stack(b)) return 0;
      b = longint'(signed'(stack_mem[b]));
    end
    if (!in_stack(b)) return 0;
    where = b;
    return 1;
  endfunction

  function void note_request(opcode_t op, logic [3:0] lvl, logic [31:0] mw, logic [31:0] rd);
    step_result_t r;
    longint m, b, npc, nbp, ra, x, y, a;
    logic [31:0] res, ux, uy;
    logic [1:0] flt;
    logic wv;
    logic [31:0] wval;
    m = longint'(signed'(mw));
    flt = FLT_NONE; wv = 0; wval = '0; b = 0;
    if (!halted) begin
      npc = (pc + 1 >= CODE) ? 0 : pc + 1;
      pc = npc;
      case (op)
        OP_LIT: begin
          if (!in_stack(sp + 1)) flt = FLT_STACK;
          else begin stack_mem[sp + 1] = mw; sp++; end
        end
        OP_OPR: begin
          if (mw == OPR_RTN) begin
            if (!in_stack(sp) || !in_stack(bp - 1) || !in_stack(bp + 2)) flt = FLT_STACK;
            else begin
              nbp = longint'(signed'(stack_mem[bp + 1]));
              ra  = longint'(signed'(stack_mem[bp + 2]));
              if (!in_stack(nbp)) flt = FLT_STACK;
              else if (!in_code(ra)) flt = FLT_JUMP;
              else begin
                stack_mem[bp - 1] = stack_mem[sp];
                sp = bp - 1; bp = nbp; pc = ra;
              end
            end
          end else if (mw == OPR_NEG || mw == OPR_ODD) begin
            if (!in_stack(sp)) flt = FLT_STACK;
            else if (mw == OPR_NEG) stack_mem[sp] = -stack_mem[sp];
            else stack_mem[sp] = {31'd0, stack_mem[sp][0]};
          end else if (m >= 2 && m <= 13) begin
            if (!in_stack(sp) || sp < 1) flt = FLT_STACK;
            else begin
              ux = stack_mem[sp - 1]; uy = stack_mem[sp];
              x = longint'(signed'(ux)); y = longint'(signed'(uy));
              res = '0;
              case (mw)
                OPR_ADD: res = ux + uy;
                OPR_SUB: res = ux - uy;
                OPR_MUL: res = ux * uy;
                OPR_DIV, OPR_MOD: begin
                  // 64-bit arithmetic keeps the most negative over minus one
                  // case well defined before truncation.
                  if (y == 0) flt = FLT_DIV0;
                  else if (mw == OPR_DIV) res = 32'(x / y);
                  else res = 32'(x % y);
                end
                OPR_EQL: res = 32'(x == y);
                OPR_NEQ: res = 32'(x != y);
                OPR_LSS: res = 32'(x < y);
                OPR_LEQ: res = 32'(x <= y);
                OPR_GTR: res = 32'(x > y);
                default: res = 32'(x >= y);
              endcase
              stack_mem[sp - 1] = res;
              sp--;
            end
          end
        end
        OP_LOD: begin
          if (!follow_links(lvl, b) || !in_stack(b + m) || !in_stack(sp + 1)) flt = FLT_STACK;
          else begin stack_mem[sp + 1] = stack_mem[b + m]; sp++; end
        end
        OP_STO: begin
          if (!follow_links(lvl, b) || !in_stack(b + m) || !in_stack(sp)) flt = FLT_STACK;
          else begin stack_mem[b + m] = stack_mem[sp]; sp--; end
        end
        OP_CAL: begin
          if (!follow_links(lvl, b) || !in_stack(sp) || !in_stack(sp + 4)) flt = FLT_STACK;
          else if (!in_code(m)) flt = FLT_JUMP;
          else begin
            stack_mem[sp + 1] = 32'(b);
            stack_mem[sp + 2] = 32'(bp);
            stack_mem[sp + 3] = 32'(npc);
            stack_mem[sp + 4] = stack_mem[sp];
            bp = sp + 1; pc = m;
          end
        end
        OP_INC: begin
          a = sp + m;
          if (a < -1 || a >= DEPTH) flt = FLT_STACK;
          else sp = a;
        end
        OP_JMP: begin
          if (!in_code(m)) flt = FLT_JUMP;
          else pc = m;
        end
        OP_JPC: begin
          if (!in_stack(sp)) flt = FLT_STACK;
          else if (stack_mem[sp] == 0 && !in_code(m)) flt = FLT_JUMP;
          else begin
            if (stack_mem[sp] == 0) pc = m;
            sp--;
          end
        end
        OP_SYS: begin
          if (mw == SYS_WRITE) begin
            if (!in_stack(sp)) flt = FLT_STACK;
            else begin wv = 1; wval = stack_mem[sp]; sp--; end
          end else if (mw == SYS_READ) begin
            if (!in_stack(sp + 1)) flt = FLT_STACK;
            else begin stack_mem[sp + 1] = rd; sp++; end
          end else if (mw == SYS_HALT) begin
            halted = 1;
          end
        end
        default: ;
      endcase
    end
    r.next_pc         = pc[6:0];
    r.frame_base_out  = bp[5:0];
    r.stack_top_index = sp[6:0];
    r.top_value       = in_stack(sp) ? stack_mem[sp] : '0;
    r.write_valid     = wv;
    r.write_value     = wval;
    r.halted_out      = halted;
    r.fault           = flt;
    pending.push_back(r);
  endfunction

  function void check_result(step_result_t got);
    step_result_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %p", $realtime, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.next_pc !== want.next_pc)
      $display("%0t: next_pc expected %0d actual %0d", $realtime, want.next_pc, got.next_pc);
    if (got.frame_base_out !== want.frame_base_out)
      $display("%0t: frame_base_out expected %0d actual %0d", $realtime,
               want.frame_base_out, got.frame_base_out);
    if (got.stack_top_index !== want.stack_top_index)
      $display("%0t: stack_top_index expected %0d actual %0d", $realtime,
               $signed(want.stack_top_index), $signed(got.stack_top_index));
    if (got.top_value !== want.top_value)
      $display("%0t: top_value expected %h actual %h", $realtime, want.top_value, got.top_value);
    if (got.write_valid !== want.write_valid)
      $display("%0t: write_valid expected %b actual %b", $realtime,
               want.write_valid, got.write_valid);
    if (got.write_value !== want.write_value)
      $display("%0t: write_value expected %h actual %h", $realtime,
               want.write_value, got.write_value);
    if (got.halted_out !== want.halted_out)
      $display("%0t: halted_out expected %b actual %b", $realtime,
               want.halted_out, got.halted_out);
    if (got.fault !== want.fault)
      $display("%0t: fault expected %0d actual %0d", $realtime, want.fault, got.fault);
    if (got !== want) errors++;
  endfunction
endclass

module testbench;
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  smx_in_if  in_ch ();
  smx_out_if out_ch ();

  stack_machine_execute uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pmachine_scoreboard board = new();

  // When set, neither side idles; this gives a long back-to-back stretch.
  bit steady = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.level = '0;
    in_ch.modifier = '0;
    in_ch.read_value = '0;
    out_ch.ready = 1'b0;
  end

  // The result side is sampled at each rising edge; ready is then redrawn for
  // the next cycle, idling about 37 times in a hundred outside the steady run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        board.check_result('{out_ch.next_pc, out_ch.frame_base_out, out_ch.stack_top_index,
                             out_ch.top_value, out_ch.write_valid, out_ch.write_value,
                             out_ch.halted_out, out_ch.fault});
      out_ch.ready <= steady || ($urandom_range(99) >= 37);
    end
  end

  // Presents one request and holds it until accepted. A random idle gap may
  // come first; the request is noted in the scoreboard at its acceptance.
  task automatic send_request(opcode_t op, logic [3:0] lvl, logic [31:0] m, logic [31:0] rd);
    while (!steady && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.level      <= lvl;
    in_ch.modifier   <= m;
    in_ch.read_value <= rd;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(op, lvl, m, rd);
  endtask

  // Biased random word: small values most of the time, so that addresses and
  // offsets land in range, with wide values and extremes mixed in.
  function automatic logic [31:0] rand_word();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 5) return 32'($signed($urandom_range(12)) - 4);
    if (k < 7) return 32'($urandom_range(127));
    if (k == 7) return $urandom();
    return ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  // Random instruction, weighted towards well-formed programme fragments:
  // pushes to build a stack, arithmetic on it, calls into small frames and
  // returns from them. A halt is rare since it freezes the machine until the
  // end of the run.
  task automatic random_request();
    int unsigned k;
    logic [3:0] lvl;
    lvl = ($urandom_range(7) == 0) ? 4'($urandom()) : 4'($urandom_range(2));
    k = $urandom_range(99);
    if (k < 22)      send_request(OP_LIT, lvl, rand_word(), $urandom());
    else if (k < 45) send_request(OP_OPR, lvl, 32'($urandom_range(13)), $urandom());
    else if (k < 47) send_request(OP_OPR, lvl, rand_word(), $urandom());
    else if (k < 55) send_request(OP_LOD, lvl, 32'($urandom_range(6)), $urandom());
    else if (k < 62) send_request(OP_STO, lvl, 32'($urandom_range(6)), $urandom());
    else if (k < 68) send_request(OP_CAL, lvl, 32'($urandom_range(127)), $urandom());
    else if (k < 74) send_request(OP_INC, lvl, rand_word(), $urandom());
    else if (k < 78) send_request(OP_JMP, lvl, rand_word(), $urandom());
    else if (k < 83) send_request(OP_JPC, lvl, rand_word(), $urandom());
    else if (k < 92) send_request(OP_SYS, lvl, 32'($urandom_range(2) + 1 == 3 ? 1 :
                                               $urandom_range(2) + 1), $urandom());
    else if (k < 99) send_request(opcode_t'($urandom()), 4'($urandom()), $urandom(), $urandom());
    else             send_request(OP_SYS, lvl, rand_word(), $urandom());
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty-stack faults, the most negative literal, every OPR
    // selector including modulo by zero and the most negative value divided
    // by minus one, a call and a return, jumps out of range, read and write.
    send_request(OP_OPR, 4'd0, OPR_ADD, '0);
    send_request(OP_SYS, 4'd0, SYS_WRITE, '0);
    send_request(OP_LIT, 4'hf, 32'h8000_0000, '0);
    send_request(OP_LIT, 4'd0, 32'hffff_ffff, '0);
    send_request(OP_OPR, 4'd0, OPR_DIV, '0);
    send_request(OP_LIT, 4'd0, 32'd0, '0);
    send_request(OP_OPR, 4'd0, OPR_MOD, '0);
    send_request(OP_SYS, 4'd0, SYS_READ, 32'h7fff_ffff);
    send_request(OP_OPR, 4'd0, OPR_ODD, '0);
    send_request(OP_OPR, 4'd0, OPR_NEG, '0);
    for (int s = 2; s <= 13; s++) begin
      send_request(OP_LIT, 4'd0, 32'(s - 7), '0);
      send_request(OP_OPR, 4'd0, 32'(s), '0);
    end
    send_request(OP_CAL, 4'd0, 32'd100, '0);
    send_request(OP_INC, 4'd0, 32'd4, '0);
    send_request(OP_LOD, 4'd1, 32'd0, '0);
    send_request(OP_STO, 4'd0, 32'd4, '0);
    send_request(OP_OPR, 4'd0, OPR_RTN, '0);
    send_request(OP_JMP, 4'd0, 32'd128, '0);
    send_request(OP_JMP, 4'd0, 32'h7fff_ffff, '0);
    send_request(OP_JPC, 4'd0, 32'hffff_ffff, '0);
    send_request(OP_INC, 4'd0, 32'h8000_0000, '0);
    send_request(OP_SYS, 4'd0, SYS_WRITE, '0);

    for (int n = 0; n < 1700; n++) begin
      steady = (n >= 600 && n < 800);
      random_request();
    end
    // A final halt shows that later requests are ignored.
    send_request(OP_SYS, 4'd0, SYS_HALT, '0);
    send_request(OP_LIT, 4'd0, 32'd5, '0);
    in_ch.valid <= 1'b0;

    waited = 0;
    while (board.pending.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // The slowest requests in the block are a call walking fifteen links and a
  // division, and random stalls on either side add to them; the timeout below
  // still leaves a wide margin for each request, clearing pass included.
  initial begin
    #(12 * 2000 * 400);
    $display("FAIL");
    $finish;
  end
endmodule

### stack_machine_execute.f
rtl/core/smx_pkg.sv
rtl/core/smx_if.sv
rtl/core/smx_ram.sv
rtl/core/smx_div.sv
rtl/core/stack_machine_execute.sv
tb/smx_tb_if.sv
tb/testbench.sv
